FILE: rtl/dnc_pkg.sv
`default_nettype none
package dnc_pkg;

   // Field and register widths
   localparam int LIGHT_W     = 10;
   localparam int SAMPLE_BITS = 10;
   localparam int THR_W       = 10;
   localparam int HOLD_W      = 10;
   localparam int WIN_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   // Low SAMPLE_BITS bits of the light field are significant
   localparam logic [LIGHT_W-1:0] SAMPLE_MASK = LIGHT_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   // Saturation point of the checks-since-switch counter
   localparam logic [WIN_W-1:0] CSS_MAX = '1;

   typedef enum logic [1:0] {
      MODE_AUTO  = 2'd0,
      MODE_DAY   = 2'd1,
      MODE_NIGHT = 2'd2,
      MODE_USER  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ACT_CHECK         = 3'd0,
      ACT_AUTO          = 3'd1,
      ACT_DAY           = 3'd2,
      ACT_NIGHT         = 3'd3,
      ACT_USER          = 3'd4,
      ACT_MANUAL_FILTER = 3'd5,
      ACT_MANUAL_LED    = 3'd6,
      ACT_RESET_MODE    = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      NOTIFY_NONE  = 2'd0,
      NOTIFY_COLOR = 2'd1,
      NOTIFY_MONO  = 2'd2
   } notify_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_MODE    = 3'd0,
      CSR_HOLD_CHECKS     = 3'd1,
      CSR_DAY_THRESHOLD   = 3'd2,
      CSR_NIGHT_THRESHOLD = 3'd3,
      CSR_RECENT_WINDOW   = 3'd4
   } csr_index_type;

   // Reset values of the configuration registers
   localparam mode_type          RST_DEFAULT_MODE = MODE_AUTO;
   localparam logic [HOLD_W-1:0] RST_HOLD_CHECKS  = 10'd6;
   localparam logic [THR_W-1:0]  RST_DAY_THR      = 10'h30;
   localparam logic [THR_W-1:0]  RST_NIGHT_THR    = 10'h20;
   localparam logic [WIN_W-1:0]  RST_WINDOW       = 6'd10;

   typedef struct packed {
      mode_type          default_mode;
      logic [HOLD_W-1:0] hold_checks;
      logic [THR_W-1:0]  day_threshold;
      logic [THR_W-1:0]  night_threshold;
      logic [WIN_W-1:0]  recent_window;
   } cfg_type;

   typedef struct packed {
      mode_type          mode;
      logic              day_flag;
      logic [HOLD_W-1:0] persist;
      logic              filter;
      logic              led;
      logic              color;
      logic [WIN_W-1:0]  css;
   } ctl_state_type;

   typedef struct packed {
      action_type         action;
      logic [LIGHT_W-1:0] light_sample;
      logic               manual_value;
   } req_word_type;

   typedef struct packed {
      logic       filter_blocks_ir;
      logic       led_on;
      logic       image_color;
      logic       light_is_day;
      mode_type   active_mode_out;
      notify_type notify_event;
      logic       recent_switch;
   } rsp_word_type;

endpackage
`default_nettype wire

FILE: rtl/dnc_ifs.sv
`default_nettype none
interface dnc_req_if import dnc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [LIGHT_W-1:0] light_sample;
   logic               manual_value;

   modport source (output valid, action, light_sample, manual_value, input ready);
   modport sink   (input valid, action, light_sample, manual_value, output ready);
endinterface

interface dnc_rsp_if;
   logic       valid;
   logic       ready;
   logic       filter_blocks_ir;
   logic       led_on;
   logic       image_color;
   logic       light_is_day;
   logic [1:0] active_mode_out;
   logic [1:0] notify_event;
   logic       recent_switch;

   modport source (output valid, filter_blocks_ir, led_on, image_color, light_is_day,
                   active_mode_out, notify_event, recent_switch, input ready);
   modport sink   (input valid, filter_blocks_ir, led_on, image_color, light_is_day,
                   active_mode_out, notify_event, recent_switch, output ready);
endinterface

interface dnc_csr_if import dnc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/dnc_step.sv
`default_nettype none
module dnc_step import dnc_pkg::*; (
   input  cfg_type       cfg,
   input  ctl_state_type cur,
   input  req_word_type  word,
   output ctl_state_type nxt,
   output rsp_word_type  rsp
);

   function automatic ctl_state_type drive_day(ctl_state_type s);
      ctl_state_type r;
      r        = s;
      r.led    = 1'b0;
      r.filter = 1'b1;
      r.color  = 1'b1;
      r.css    = '0;
      return r;
   endfunction

   function automatic ctl_state_type drive_night(ctl_state_type s);
      ctl_state_type r;
      r        = s;
      r.filter = 1'b0;
      r.led    = 1'b1;
      r.color  = 1'b0;
      r.css    = '0;
      return r;
   endfunction

   logic [LIGHT_W-1:0] sample;
   logic [THR_W:0]     thr_sum;
   logic [THR_W-1:0]   midpoint;
   logic               out_of_band;
   logic [HOLD_W:0]    step_count;
   notify_type         notify;

   // Compare terms for check and auto; only the masked sample is used by both
   assign sample      = word.light_sample & SAMPLE_MASK;
   assign thr_sum     = {1'b0, cfg.day_threshold} + {1'b0, cfg.night_threshold};
   assign midpoint    = thr_sum[THR_W:1];
   assign out_of_band = (cur.day_flag && (sample < cfg.night_threshold)) ||
                        (!cur.day_flag && (sample > cfg.day_threshold));
   assign step_count  = {1'b0, cur.persist} + {{HOLD_W{1'b0}}, 1'b1};

   // Next state per action
   always_comb begin
      nxt    = cur;
      notify = NOTIFY_NONE;
      case (word.action)
         ACT_CHECK: begin
            if (cur.css != CSS_MAX) begin
               nxt.css = cur.css + {{(WIN_W-1){1'b0}}, 1'b1};
            end
            if (cur.mode == MODE_AUTO) begin
               if (out_of_band) begin
                  if (step_count > {1'b0, cfg.hold_checks}) begin
                     if (cur.day_flag) begin
                        nxt    = drive_night(nxt);
                        notify = NOTIFY_MONO;
                     end else begin
                        nxt    = drive_day(nxt);
                        notify = NOTIFY_COLOR;
                     end
                     nxt.day_flag = !cur.day_flag;
                     nxt.persist  = '0;
                  end else begin
                     nxt.persist = step_count[HOLD_W-1:0];
                  end
               end else begin
                  nxt.persist = '0;
               end
            end
         end
         ACT_AUTO: begin
            if (sample > midpoint) begin
               nxt    = drive_day(cur);
               notify = NOTIFY_COLOR;
            end else begin
               nxt    = drive_night(cur);
               notify = NOTIFY_MONO;
            end
            nxt.day_flag = (sample > midpoint);
            nxt.mode     = MODE_AUTO;
         end
         ACT_DAY: begin
            nxt      = drive_day(cur);
            nxt.mode = MODE_DAY;
            notify   = NOTIFY_COLOR;
         end
         ACT_NIGHT: begin
            nxt      = drive_night(cur);
            nxt.mode = MODE_NIGHT;
            notify   = NOTIFY_MONO;
         end
         ACT_USER: begin
            nxt.mode = MODE_USER;
         end
         ACT_MANUAL_FILTER: begin
            nxt.filter = word.manual_value;
            nxt.css    = '0;
            nxt.mode   = MODE_USER;
         end
         ACT_MANUAL_LED: begin
            nxt.led  = word.manual_value;
            nxt.css  = '0;
            nxt.mode = MODE_USER;
         end
         ACT_RESET_MODE: begin
            nxt.mode = cfg.default_mode;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // Result word from the updated state
   always_comb begin
      rsp.filter_blocks_ir = nxt.filter;
      rsp.led_on           = nxt.led;
      rsp.image_color      = nxt.color;
      rsp.light_is_day     = nxt.day_flag;
      rsp.active_mode_out  = nxt.mode;
      rsp.notify_event     = notify;
      rsp.recent_switch    = (nxt.css < cfg.recent_window);
   end

endmodule
`default_nettype wire

FILE: rtl/day_night_ircut_controller.sv
`default_nettype none
// Channel   Dir   Protocol     Word
// req_ch    in    valid/ready  action, light_sample, manual_value
// rsp_ch    out   valid/ready  filter/led/color/day, mode, notify, recent flag
// csr_ch    in    valid/ready  register index, write data (always ready)
//
// rsp valid rises once an accepted req word has passed the input register and the result
// register; one word per cycle sustained while rsp is not stalled. The rate is set by the
// combinational state update in dnc_step between the input and result registers.
// Synchronous reset restores config and control state to defaults, mode auto, day, filter in.
// A stalled rsp holds its word; req stays ready while the input stage can move on.
module day_night_ircut_controller import dnc_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   dnc_req_if.sink    req_ch,
   dnc_rsp_if.source  rsp_ch,
   dnc_csr_if.sink    csr_ch
);

   cfg_type       cfg_ff, cfg_in;
   ctl_state_type ctl_ff, ctl_nxt;
   req_word_type  req_word_ff;
   logic          req_vld_ff;
   rsp_word_type  rsp_word_ff, rsp_word;
   logic          rsp_vld_ff;
   logic          advance;
   logic          req_take;

   // Handshakes
   assign advance      = req_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !req_vld_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_DEFAULT_MODE:    cfg_in.default_mode    = mode_type'(csr_ch.data[1:0]);
            CSR_HOLD_CHECKS:     cfg_in.hold_checks     = csr_ch.data[HOLD_W-1:0];
            CSR_DAY_THRESHOLD:   cfg_in.day_threshold   = csr_ch.data[THR_W-1:0];
            CSR_NIGHT_THRESHOLD: cfg_in.night_threshold = csr_ch.data[THR_W-1:0];
            CSR_RECENT_WINDOW:   cfg_in.recent_window   = csr_ch.data[WIN_W-1:0];
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   dnc_step u_step (
      .cfg  (cfg_ff),
      .cur  (ctl_ff),
      .word (req_word_ff),
      .nxt  (ctl_nxt),
      .rsp  (rsp_word)
   );

   // Control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_mode    <= RST_DEFAULT_MODE;
         cfg_ff.hold_checks     <= RST_HOLD_CHECKS;
         cfg_ff.day_threshold   <= RST_DAY_THR;
         cfg_ff.night_threshold <= RST_NIGHT_THR;
         cfg_ff.recent_window   <= RST_WINDOW;
         ctl_ff.mode            <= RST_DEFAULT_MODE;
         ctl_ff.day_flag        <= 1'b1;
         ctl_ff.persist         <= '0;
         ctl_ff.filter          <= 1'b1;
         ctl_ff.led             <= 1'b0;
         ctl_ff.color           <= 1'b1;
         ctl_ff.css             <= CSS_MAX;
         req_vld_ff             <= 1'b0;
         rsp_vld_ff             <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (advance) begin
            ctl_ff <= ctl_nxt;
         end
         if (req_ch.ready) begin
            req_vld_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_word_ff.action       <= action_type'(req_ch.action);
         req_word_ff.light_sample <= req_ch.light_sample;
         req_word_ff.manual_value <= req_ch.manual_value;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word;
      end
   end

   // Drive result word
   assign rsp_ch.valid            = rsp_vld_ff;
   assign rsp_ch.filter_blocks_ir = rsp_word_ff.filter_blocks_ir;
   assign rsp_ch.led_on           = rsp_word_ff.led_on;
   assign rsp_ch.image_color      = rsp_word_ff.image_color;
   assign rsp_ch.light_is_day     = rsp_word_ff.light_is_day;
   assign rsp_ch.active_mode_out  = rsp_word_ff.active_mode_out;
   assign rsp_ch.notify_event     = rsp_word_ff.notify_event;
   assign rsp_ch.recent_switch    = rsp_word_ff.recent_switch;

endmodule
`default_nettype wire

FILE: rtl/dnc_checker.sv
`default_nettype none
module dnc_checker import dnc_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   dnc_rsp_if.source rsp_ch
);

   // Hold a stalled result word: valid, notify, mode, filter and led stay stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid &&
         $stable(rsp_ch.notify_event) && $stable(rsp_ch.active_mode_out) &&
         $stable(rsp_ch.filter_blocks_ir) && $stable(rsp_ch.led_on))
      else $error("result word changed while stalled");

   // Drop pending results on reset
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   // A switch to color drives all day outputs together
   a_color_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.notify_event == NOTIFY_COLOR |->
         rsp_ch.filter_blocks_ir && !rsp_ch.led_on && rsp_ch.image_color)
      else $error("color notify without day outputs");

   // A switch to mono drives all night outputs together
   a_mono_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.notify_event == NOTIFY_MONO |->
         !rsp_ch.filter_blocks_ir && rsp_ch.led_on && !rsp_ch.image_color)
      else $error("mono notify without night outputs");

endmodule

bind day_night_ircut_controller dnc_checker u_dnc_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);
`default_nettype wire
